### hw/rtl/mcpg_pkg.sv
`default_nettype none
package mcpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int MAX_RADIUS = 10;

  localparam int RADIUS_W = 4;
  localparam int COLOR_W  = 32;
  localparam int PIX_W    = 11;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // signed offsets and decision term, wide enough for a zero radius stepping below zero
  localparam int OFS_W  = 6;
  localparam int TERM_W = 8;

  // signed point coordinate: centre plus or minus an offset
  localparam int PT_W = COORD_BITS + 2;

  // floor(2v/5) by reciprocal multiply
  localparam int SCALE_SHIFT = 20;
  localparam int SCALE_MUL_W = 18;
  localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = SCALE_MUL_W'((2 ** SCALE_SHIFT) / 5 + 1);
  localparam int PROD_W = (PT_W + SCALE_MUL_W > SCALE_SHIFT + PIX_W) ?
                          (PT_W + SCALE_MUL_W) : (SCALE_SHIFT + PIX_W);

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(10);
  localparam logic [COLOR_W-1:0]  COLOR_RESET  = 32'h0099_FFFF;

  localparam logic [2:0] PT_LAST = 3'd7;

  typedef enum logic {
    REG_RADIUS = 1'b0,
    REG_COLOR  = 1'b1
  } mcpg_reg_t;

  typedef struct packed {
    logic load;
    logic emit;
  } mcpg_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic last_pt;
  } mcpg_sts_t;

  function automatic logic [PIX_W-1:0] scale_coord(input logic [PT_W-2:0] v);
    logic [PROD_W-1:0] v2;
    logic [PROD_W-1:0] prod;
    v2   = PROD_W'({v, 1'b0});
    prod = v2 * PROD_W'(SCALE_MUL);
    return prod[SCALE_SHIFT +: PIX_W];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/mcpg_if.sv
`default_nettype none
interface mcpg_req_if import mcpg_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] centre_x;
  logic [COORD_BITS-1:0] centre_y;

  modport source (output valid, output centre_x, output centre_y, input ready);
  modport sink   (input valid, input centre_x, input centre_y, output ready);
endinterface

interface mcpg_pix_if import mcpg_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;
  logic [COLOR_W-1:0] pixel_color;
  logic               on_image;
  logic               last_point;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                  output on_image, output last_point, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                  input on_image, input last_point, output ready);
endinterface
`default_nettype wire

### hw/rtl/midpoint_circle_point_generator.sv
// midpoint circle point generator
// in_req carries one draw request (centre_x, centre_y); out_pix returns the
// points of the circle around it, eight per midpoint step, in octant order,
// each on-image point scaled to floor(2v/5), with the draw colour, an on_image flag and a
// last_point marker on the final point of the run.
// the apb-style port holds circle_radius (byte address 0, saturated to 10 when
// used) and draw_color (byte address 4); write them only while the block idles.
// a request is taken, then one point is produced per cycle while the output
// slot is free, so a run of S steps gives 8*S points; S is the number of
// midpoint iterations, 8 at radius 10 (64 points), 1 at radius 0.
// the request is loaded first, then its first point is registered on out_pix.
// requests are taken one at a time: in_req.ready is high only between runs,
// and the next request can be accepted while the last point still waits.
// when out_pix.ready is low while a point waits, the output register holds and
// the point sequencer pauses, so no point is lost or repeated.
// reset clears the controller and output valid and loads radius 10 and colour
// 0x0099ffff; it is synchronous, there is no clearing pass.
`default_nettype none
module midpoint_circle_point_generator import mcpg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  mcpg_req_if.sink               in_req,
  mcpg_pix_if.source             out_pix,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  logic [RADIUS_W-1:0] radius;
  logic [COLOR_W-1:0]  color;
  mcpg_cmd_t           cmd;
  mcpg_sts_t           sts;

  mcpg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .radius  (radius),
    .color   (color)
  );

  mcpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mcpg_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .centre_x    (in_req.centre_x),
    .centre_y    (in_req.centre_y),
    .radius      (radius),
    .color       (color),
    .out_valid   (out_pix.valid),
    .out_ready   (out_pix.ready),
    .pixel_x     (out_pix.pixel_x),
    .pixel_y     (out_pix.pixel_y),
    .pixel_color (out_pix.pixel_color),
    .on_image    (out_pix.on_image),
    .last_point  (out_pix.last_point)
  );

endmodule
`default_nettype wire

### hw/rtl/mcpg_cfg_regs.sv
`default_nettype none
module mcpg_cfg_regs import mcpg_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  output logic      [DATA_W-1:0]   prdata,
  output logic                     pready,
  output logic      [RADIUS_W-1:0] radius,
  output logic      [COLOR_W-1:0]  color
);

  logic [RADIUS_W-1:0] radius_r;
  logic [COLOR_W-1:0]  color_r;
  logic                wr_en;
  mcpg_reg_t           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = mcpg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
      color_r  <= COLOR_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_RADIUS: radius_r <= pwdata[RADIUS_W-1:0];
        REG_COLOR:  color_r  <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (reg_sel)
        REG_RADIUS: prdata = DATA_W'(radius_r);
        REG_COLOR:  prdata = DATA_W'(color_r);
        default:    prdata = '0;
      endcase
    end
  end

  assign radius = radius_r;
  assign color  = color_r;

endmodule
`default_nettype wire

### hw/rtl/mcpg_ctrl.sv
`default_nettype none
module mcpg_ctrl import mcpg_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire mcpg_sts_t sts,
  output mcpg_cmd_t      cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cmd.emit = sts.slot_free;
        if (sts.slot_free && sts.last_pt) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule
`default_nettype wire

### hw/rtl/mcpg_datapath.sv
`default_nettype none
module mcpg_datapath import mcpg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mcpg_cmd_t             cmd,
  output mcpg_sts_t                  sts,
  input  wire logic [COORD_BITS-1:0] centre_x,
  input  wire logic [COORD_BITS-1:0] centre_y,
  input  wire logic [RADIUS_W-1:0]   radius,
  input  wire logic [COLOR_W-1:0]    color,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [PIX_W-1:0]      pixel_x,
  output logic      [PIX_W-1:0]      pixel_y,
  output logic      [COLOR_W-1:0]    pixel_color,
  output logic                       on_image,
  output logic                       last_point
);

  logic [COORD_BITS-1:0]    cx_r, cy_r;
  logic signed [OFS_W-1:0]  major_r, minor_r;
  logic signed [TERM_W-1:0] term_r;
  logic [2:0]               pt_r;

  logic [RADIUS_W-1:0]      radius_eff;
  logic signed [OFS_W-1:0]  minor_inc, major_step;
  logic signed [TERM_W-1:0] minor_ext, major_ext, term_step;
  logic                     run_end;

  logic signed [OFS_W-1:0]  dx, dy;
  logic signed [PT_W-1:0]   cx_s, cy_s, dx_e, dy_e, px, py;
  logic                     pt_on;

  logic                     out_valid_r;
  logic [PIX_W-1:0]         pixel_x_r, pixel_y_r;
  logic [COLOR_W-1:0]       pixel_color_r;
  logic                     on_image_r, last_point_r;

  assign radius_eff = (radius > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius;

  // one midpoint step, applied after the eighth point
  always_comb begin
    minor_inc  = minor_r + OFS_W'(1);
    minor_ext  = TERM_W'(minor_inc);
    major_step = major_r;
    major_ext  = TERM_W'(major_r);
    term_step  = term_r + (minor_ext <<< 1) + TERM_W'(1);
    if (!term_r[TERM_W-1]) begin
      major_step = major_r - OFS_W'(1);
      major_ext  = TERM_W'(major_step);
      term_step  = term_r + ((minor_ext - major_ext + TERM_W'(1)) <<< 1);
    end
  end

  assign run_end   = (major_step < minor_inc);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r    <= centre_x;
      cy_r    <= centre_y;
      major_r <= OFS_W'(radius_eff);
      minor_r <= '0;
      term_r  <= TERM_W'(1) - TERM_W'(radius_eff);
      pt_r    <= '0;
    end else if (cmd.emit) begin
      pt_r <= pt_r + 3'd1;
      if (pt_r == PT_LAST) begin
        major_r <= major_step;
        minor_r <= minor_inc;
        term_r  <= term_step;
      end
    end
  end

  // bit 1 swaps the offsets, bit 0 mirrors x, bit 2 mirrors y
  always_comb begin
    dx   = pt_r[1] ? minor_r : major_r;
    dy   = pt_r[1] ? major_r : minor_r;
    cx_s = signed'(PT_W'(cx_r));
    cy_s = signed'(PT_W'(cy_r));
    dx_e = PT_W'(dx);
    dy_e = PT_W'(dy);
    px   = pt_r[0] ? (cx_s - dx_e) : (cx_s + dx_e);
    py   = pt_r[2] ? (cy_s + dy_e) : (cy_s - dy_e);
  end

  assign pt_on = !px[PT_W-1] && !py[PT_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_x_r     <= pt_on ? scale_coord(px[PT_W-2:0]) : '0;
      pixel_y_r     <= pt_on ? scale_coord(py[PT_W-2:0]) : '0;
      pixel_color_r <= color;
      on_image_r    <= pt_on;
      last_point_r  <= sts.last_pt;
    end
  end

  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.last_pt   = (pt_r == PT_LAST) && run_end;

  assign out_valid   = out_valid_r;
  assign pixel_x     = pixel_x_r;
  assign pixel_y     = pixel_y_r;
  assign pixel_color = pixel_color_r;
  assign on_image    = on_image_r;
  assign last_point  = last_point_r;

endmodule
`default_nettype wire

### test/midpoint_circle_point_generator_tb.sv
module midpoint_circle_point_generator_tb import mcpg_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int RUN_POINTS  = 64;
  localparam int RANDOM_ITEMS = 220;
  localparam int PHASE_ITEMS  = 20;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               on_image;
    logic               last_point;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  mcpg_req_if req_if ();
  mcpg_pix_if pix_if ();

  midpoint_circle_point_generator dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_if.sink),
    .out_pix (pix_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // shadow copy of the configuration registers
  logic [RADIUS_W-1:0] radius_reg = RADIUS_RESET;
  logic [COLOR_W-1:0]  color_reg  = COLOR_RESET;

  pixel_t pending_pixels[$];
  int     error_count = 0;
  int     cycle_count = 0;

  // idling controls: max gap per transaction for each side, plus a long hold-off
  int src_max  = 0;
  int sink_max = 0;
  int sink_wait = 0;
  int sink_hold = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic pixel_t make_pixel(input int px, input int py);
    pixel_t p;
    p.on_image    = (px >= 0) && (py >= 0);
    p.pixel_x     = p.on_image ? PIX_W'((px * 2) / 5) : '0;
    p.pixel_y     = p.on_image ? PIX_W'((py * 2) / 5) : '0;
    p.pixel_color = color_reg;
    p.last_point  = 1'b0;
    return p;
  endfunction

  // midpoint loop over one octant, eight mirrored points per step
  function automatic void plot_circle(input logic [COORD_BITS-1:0] cx,
                                      input logic [COORD_BITS-1:0] cy);
    int major;
    int minor;
    int term;
    int dx[8];
    int dy[8];
    pixel_t run[$];
    major = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
    minor = 0;
    term  = 1 - major;
    while (major >= minor && run.size() + 8 <= RUN_POINTS) begin
      dx = '{major, -major, minor, -minor, major, -major, minor, -minor};
      dy = '{-minor, -minor, -major, -major, minor, minor, major, major};
      for (int k = 0; k < 8; k++) begin
        run.push_back(make_pixel(int'(cx) + dx[k], int'(cy) + dy[k]));
      end
      minor++;
      if (term < 0) begin
        term += 2 * minor + 1;
      end else begin
        major--;
        term += 2 * (minor - major + 1);
      end
    end
    run[run.size() - 1].last_point = 1'b1;
    foreach (run[i]) pending_pixels.push_back(run[i]);
  endfunction

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && pix_if.valid && pix_if.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel transaction x=%0d y=%0d", pix_if.pixel_x, pix_if.pixel_y);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (pix_if.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", want.pixel_x, pix_if.pixel_x);
          error_count++;
        end
        if (pix_if.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", want.pixel_y, pix_if.pixel_y);
          error_count++;
        end
        if (pix_if.pixel_color !== want.pixel_color) begin
          $error("pixel_color: expected %h, got %h", want.pixel_color, pix_if.pixel_color);
          error_count++;
        end
        if (pix_if.on_image !== want.on_image) begin
          $error("on_image: expected %0d, got %0d", want.on_image, pix_if.on_image);
          error_count++;
        end
        if (pix_if.last_point !== want.last_point) begin
          $error("last_point: expected %0d, got %0d", want.last_point, pix_if.last_point);
          error_count++;
        end
      end
      sink_wait = (sink_max == 0) ? 0 : $urandom_range(0, sink_max);
    end
  end

  initial begin : pixel_sink
    pix_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        pix_if.ready <= 1'b0;
        sink_hold--;
      end else if (sink_wait > 0) begin
        pix_if.ready <= 1'b0;
        sink_wait--;
      end else begin
        pix_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [COORD_BITS-1:0] cx,
                              input logic [COORD_BITS-1:0] cy);
    int gap;
    gap = (src_max == 0) ? 0 : $urandom_range(0, src_max);
    repeat (gap) begin
      @(negedge clk);
      req_if.valid    <= 1'b0;
      req_if.centre_x <= COORD_BITS'($urandom());
      req_if.centre_y <= COORD_BITS'($urandom());
    end
    @(negedge clk);
    req_if.valid    <= 1'b1;
    req_if.centre_x <= cx;
    req_if.centre_y <= cy;
    do @(posedge clk); while (!req_if.ready);
    plot_circle(cx, cy);
  endtask

  task automatic apb_xfer(input mcpg_reg_t idx, input logic wr, input logic [DATA_W-1:0] wdata,
                          output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_reg(input mcpg_reg_t idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] unused;
    apb_xfer(idx, 1'b1, value, unused);
    if (idx == REG_RADIUS) radius_reg = value[RADIUS_W-1:0];
    else color_reg = value;
  endtask

  task automatic check_reg(input mcpg_reg_t idx);
    logic [DATA_W-1:0] got;
    apb_xfer(idx, 1'b0, '0, got);
    if (idx == REG_RADIUS && got[RADIUS_W-1:0] !== radius_reg) begin
      $error("circle_radius: expected %0d, got %0d", radius_reg, got[RADIUS_W-1:0]);
      error_count++;
    end
    if (idx == REG_COLOR && got !== color_reg) begin
      $error("draw_color: expected %h, got %h", color_reg, got);
      error_count++;
    end
  endtask

  // drop valid and wait for every predicted point to come out
  task automatic drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return COORD_BITS'($urandom_range(0, 15));
      1: return COORD_BITS'($urandom_range(4080, 4095));
      default: return COORD_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic test_reset_state();
    check_reg(REG_RADIUS);
    check_reg(REG_COLOR);
    send_request(12'd2048, 12'd2048);
    send_request(12'd0, 12'd0);
    send_request(12'd4095, 12'd4095);
    drain();
  endtask

  // zero radius, saturation above the limit and the corners of the map
  task automatic test_radius_extremes();
    write_reg(REG_RADIUS, 32'd0);
    check_reg(REG_RADIUS);
    send_request(12'd0, 12'd0);
    send_request(12'd4095, 12'd4095);
    drain();
    write_reg(REG_RADIUS, 32'd15);
    check_reg(REG_RADIUS);
    send_request(12'd0, 12'd4095);
    send_request(12'd4095, 12'd0);
    drain();
    write_reg(REG_RADIUS, 32'd11);
    send_request(12'd7, 12'd9);
    drain();
    write_reg(REG_RADIUS, 32'd1);
    send_request(12'd1, 12'd0);
    drain();
    write_reg(REG_RADIUS, 32'd10);
    send_request(12'd10, 12'd10);
    drain();
  endtask

  task automatic test_color_extremes();
    write_reg(REG_COLOR, 32'h0000_0000);
    check_reg(REG_COLOR);
    send_request(12'd100, 12'd200);
    drain();
    write_reg(REG_COLOR, 32'hFFFF_FFFF);
    check_reg(REG_COLOR);
    send_request(12'd3000, 12'd5);
    drain();
    write_reg(REG_COLOR, 32'hA5A5_5A5A);
    send_request(12'd2, 12'd4093);
    drain();
  endtask

  // sink stalls for a long stretch while requests keep coming
  task automatic test_output_stall();
    src_max  = 0;
    sink_max = 0;
    sink_hold = 400;
    for (int i = 0; i < 4; i++) send_request(pick_coord(), pick_coord());
    drain();
  endtask

  task automatic test_random_circles();
    int r;
    for (int done = 0; done < RANDOM_ITEMS; done += PHASE_ITEMS) begin
      case ($urandom_range(0, 5))
        0: r = 0;
        1: r = 15;
        2: r = 10;
        default: r = $urandom_range(0, 15);
      endcase
      write_reg(REG_RADIUS, 32'(r));
      write_reg(REG_COLOR, $urandom());
      src_max  = ($urandom_range(0, 3) == 0) ? 0 : 14;
      sink_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == 5 && $urandom_range(0, 2) == 0) sink_hold = $urandom_range(200, 400);
        send_request(pick_coord(), pick_coord());
      end
      drain();
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    req_if.valid    <= 1'b0;
    req_if.centre_x <= '0;
    req_if.centre_y <= '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_radius_extremes();
    test_color_extremes();
    test_output_stall();
    test_random_circles();

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/mcpg_pkg.sv
hw/rtl/mcpg_if.sv
hw/rtl/mcpg_cfg_regs.sv
hw/rtl/mcpg_ctrl.sv
hw/rtl/mcpg_datapath.sv
hw/rtl/midpoint_circle_point_generator.sv
test/midpoint_circle_point_generator_tb.sv
